FILE: rtl/ffha_pkg.sv
package ffha_pkg;

	localparam int HEAP_BYTES = 1024;
	localparam int MAX_BLOCKS = 64;
	localparam int FREE_DEPTH = MAX_BLOCKS + 1;
	localparam int AW = $clog2(HEAP_BYTES);
	localparam int SW = AW + 1;
	localparam int EW = AW + 2;
	localparam int IW = $clog2(FREE_DEPTH + 1);
	localparam int MLW = 10;
	localparam logic [MLW-1:0] MIN_LEFTOVER_RST = MLW'(3);

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE = 1'b1;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_ZERO = 3'd1,
		ST_NOFIT = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_FULL = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC_SEG,
		S_ALLOC_USED,
		S_FREE_SCAN,
		S_FREE_UPD,
		S_DONE
	} state_t;

	typedef struct packed {
		logic vld;
		logic [AW-1:0] start;
		logic [SW-1:0] size;
	} ent_t;

	typedef struct packed {
		logic seg_shift;
		logic used_shift;
	} ring_ctl_t;

	typedef struct packed {
		logic command;
		logic [SW-1:0] request_size;
		logic [AW-1:0] block_address;
	} in_t;

	typedef struct packed {
		logic [2:0] status;
		logic [AW-1:0] granted_address;
		logic [SW-1:0] granted_size;
	} out_t;

endpackage

FILE: rtl/ffha_cell.sv
module ffha_cell (
	input logic clk,
	input logic arst_n,
	input logic shift,
	input ffha_pkg::ent_t init,
	input ffha_pkg::ent_t d,
	output ffha_pkg::ent_t q
);

	ffha_pkg::ent_t ent_q;

	// each cycle of a pass the entry moves one place towards the head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= init;
		end else if (shift) begin
			ent_q <= d;
		end
	end

	assign q = ent_q;

endmodule

FILE: rtl/ffha_ctrl.sv
module ffha_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input ffha_pkg::in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output ffha_pkg::out_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [ffha_pkg::MLW-1:0] cfg_data,
	input ffha_pkg::ent_t seg_head,
	input ffha_pkg::ent_t seg_next,
	output ffha_pkg::ent_t seg_tail,
	input ffha_pkg::ent_t used_head,
	output ffha_pkg::ent_t used_tail,
	output ffha_pkg::ring_ctl_t ring_ctl
);

	localparam logic [ffha_pkg::IW-1:0] LAST_SEG = ffha_pkg::IW'(ffha_pkg::FREE_DEPTH - 1);
	localparam logic [ffha_pkg::IW-1:0] LAST_USED = ffha_pkg::IW'(ffha_pkg::MAX_BLOCKS - 1);
	localparam logic [ffha_pkg::IW-1:0] USED_CNT_MAX = ffha_pkg::IW'(ffha_pkg::MAX_BLOCKS);
	localparam logic [ffha_pkg::IW-1:0] POS_END = ffha_pkg::IW'(ffha_pkg::FREE_DEPTH);

	ffha_pkg::state_t state_q, state_d;
	logic [ffha_pkg::IW-1:0] ucnt_q;
	logic out_valid_q;
	logic [ffha_pkg::MLW-1:0] minl_q;
	ffha_pkg::out_t out_q;

	logic [ffha_pkg::SW-1:0] req_q;
	logic [ffha_pkg::AW-1:0] addr_q;
	logic [ffha_pkg::IW-1:0] idx_q;
	ffha_pkg::status_t status_q;
	logic [ffha_pkg::AW-1:0] res_addr_q;
	logic [ffha_pkg::SW-1:0] res_size_q;
	logic found_q;
	logic del_q;
	logic ins_q;
	ffha_pkg::ent_t hold_q;
	logic pos_found_q;
	logic [ffha_pkg::IW-1:0] pos_q;
	logic mprev_q;
	logic [ffha_pkg::EW-1:0] prev_end_q;
	logic next_vld_q;
	logic [ffha_pkg::AW-1:0] next_start_q;
	logic [ffha_pkg::SW-1:0] next_size_q;
	logic full_q;

	logic last_seg, last_used, used_scan;
	logic fit_hit, absorb, uhit, pos_hit, mnext, done_load;
	logic [ffha_pkg::SW-1:0] left;
	logic [ffha_pkg::EW-1:0] head_end, addr_ext;
	logic [ffha_pkg::IW-1:0] pos_m1;
	ffha_pkg::ent_t del_tail;

	assign last_seg = idx_q == LAST_SEG;
	assign last_used = idx_q == LAST_USED;
	assign used_scan = idx_q < USED_CNT_MAX;
	assign left = seg_head.size - req_q;
	assign fit_hit = !found_q && !del_q && seg_head.vld && (seg_head.size >= req_q);
	assign absorb = left <= ffha_pkg::SW'(minl_q);
	assign uhit = !found_q && used_scan && used_head.vld && (used_head.start == addr_q);
	assign pos_hit = !seg_head.vld || (seg_head.start >= addr_q);
	assign head_end = ffha_pkg::EW'(seg_head.start) + ffha_pkg::EW'(seg_head.size);
	assign addr_ext = ffha_pkg::EW'(addr_q);
	assign mnext = next_vld_q &&
		((addr_ext + ffha_pkg::EW'(res_size_q)) == ffha_pkg::EW'(next_start_q));
	assign pos_m1 = pos_q - 1'b1;
	// closing the gap: take the entry behind the head, the wrapped-round one is dropped
	assign del_tail = last_seg ? '0 : seg_next;
	assign done_load = (state_q == ffha_pkg::S_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ffha_pkg::S_IDLE: begin
				if (in_valid) begin
					if (in_data.command == ffha_pkg::CMD_FREE) begin
						state_d = ffha_pkg::S_FREE_SCAN;
					end else if (in_data.request_size == '0 || ucnt_q == USED_CNT_MAX) begin
						state_d = ffha_pkg::S_DONE;
					end else begin
						state_d = ffha_pkg::S_ALLOC_SEG;
					end
				end
			end
			ffha_pkg::S_ALLOC_SEG: begin
				if (last_seg) begin
					state_d = (found_q || fit_hit) ? ffha_pkg::S_ALLOC_USED : ffha_pkg::S_DONE;
				end
			end
			ffha_pkg::S_ALLOC_USED: begin
				if (last_used) begin
					state_d = ffha_pkg::S_DONE;
				end
			end
			ffha_pkg::S_FREE_SCAN: begin
				if (last_seg) begin
					state_d = (found_q || uhit) ? ffha_pkg::S_FREE_UPD : ffha_pkg::S_DONE;
				end
			end
			ffha_pkg::S_FREE_UPD: begin
				if (last_seg) begin
					state_d = ffha_pkg::S_DONE;
				end
			end
			ffha_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ffha_pkg::S_IDLE;
				end
			end
			default: state_d = ffha_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		seg_tail = seg_head;
		used_tail = used_head;
		ring_ctl = '0;
		in_ready = state_q == ffha_pkg::S_IDLE;
		cfg_ready = 1'b1;
		case (state_q)
			ffha_pkg::S_ALLOC_SEG: begin
				ring_ctl.seg_shift = 1'b1;
				if (del_q) begin
					seg_tail = del_tail;
				end else if (fit_hit) begin
					if (absorb) begin
						seg_tail = del_tail;
					end else begin
						seg_tail = '{vld: 1'b1,
							start: seg_head.start + req_q[ffha_pkg::AW-1:0],
							size: left};
					end
				end
			end
			ffha_pkg::S_ALLOC_USED: begin
				ring_ctl.used_shift = 1'b1;
				if (!found_q && !used_head.vld) begin
					used_tail = '{vld: 1'b1, start: res_addr_q, size: res_size_q};
				end
			end
			ffha_pkg::S_FREE_SCAN: begin
				ring_ctl.seg_shift = 1'b1;
				ring_ctl.used_shift = used_scan;
				if (uhit) begin
					used_tail = '0;
				end
			end
			ffha_pkg::S_FREE_UPD: begin
				ring_ctl.seg_shift = 1'b1;
				if (del_q) begin
					seg_tail = del_tail;
				end else if (ins_q) begin
					seg_tail = hold_q;
				end
				if (mprev_q && idx_q == pos_m1) begin
					seg_tail = '{vld: 1'b1, start: seg_head.start,
						size: seg_head.size + res_size_q + (mnext ? next_size_q : '0)};
				end else if (!mprev_q && mnext && idx_q == pos_q) begin
					seg_tail = '{vld: 1'b1, start: addr_q, size: seg_head.size + res_size_q};
				end else if (!mprev_q && !mnext && !full_q && idx_q == pos_q) begin
					seg_tail = '{vld: 1'b1, start: addr_q, size: res_size_q};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffha_pkg::S_IDLE;
			ucnt_q <= '0;
			out_valid_q <= 1'b0;
			minl_q <= ffha_pkg::MIN_LEFTOVER_RST;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				minl_q <= cfg_data;
			end
			if (state_q == ffha_pkg::S_ALLOC_USED && last_used) begin
				ucnt_q <= ucnt_q + 1'b1;
			end else if (state_q == ffha_pkg::S_FREE_SCAN && last_seg && (found_q || uhit)) begin
				ucnt_q <= ucnt_q - 1'b1;
			end
			if (done_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done_load) begin
			out_q <= '{status: status_q, granted_address: res_addr_q, granted_size: res_size_q};
		end
		case (state_q)
			ffha_pkg::S_IDLE: begin
				req_q <= in_data.request_size;
				addr_q <= in_data.block_address;
				idx_q <= '0;
				found_q <= 1'b0;
				del_q <= 1'b0;
				ins_q <= 1'b0;
				pos_found_q <= 1'b0;
				pos_q <= '0;
				mprev_q <= 1'b0;
				prev_end_q <= '0;
				next_vld_q <= 1'b0;
				next_start_q <= '0;
				next_size_q <= '0;
				full_q <= 1'b0;
				res_addr_q <= '0;
				res_size_q <= '0;
				if (in_data.command == ffha_pkg::CMD_FREE) begin
					status_q <= ffha_pkg::ST_OK;
				end else if (in_data.request_size == '0) begin
					status_q <= ffha_pkg::ST_ZERO;
				end else if (ucnt_q == USED_CNT_MAX) begin
					status_q <= ffha_pkg::ST_FULL;
				end else begin
					status_q <= ffha_pkg::ST_OK;
				end
			end
			ffha_pkg::S_ALLOC_SEG: begin
				idx_q <= idx_q + 1'b1;
				if (fit_hit) begin
					found_q <= 1'b1;
					res_addr_q <= seg_head.start;
					res_size_q <= absorb ? seg_head.size : req_q;
					if (absorb) begin
						del_q <= 1'b1;
					end
				end
				if (last_seg) begin
					idx_q <= '0;
					found_q <= 1'b0;
					if (!(found_q || fit_hit)) begin
						status_q <= ffha_pkg::ST_NOFIT;
					end
				end
			end
			ffha_pkg::S_ALLOC_USED: begin
				idx_q <= idx_q + 1'b1;
				if (!found_q && !used_head.vld) begin
					found_q <= 1'b1;
				end
			end
			ffha_pkg::S_FREE_SCAN: begin
				idx_q <= idx_q + 1'b1;
				if (uhit) begin
					found_q <= 1'b1;
					res_size_q <= used_head.size;
				end
				// insertion point and both neighbours are gathered as the ring goes by
				if (!pos_found_q) begin
					if (pos_hit) begin
						pos_found_q <= 1'b1;
						pos_q <= idx_q;
						mprev_q <= (idx_q != '0) && (prev_end_q == addr_ext);
						next_vld_q <= seg_head.vld;
						next_start_q <= seg_head.start;
						next_size_q <= seg_head.size;
					end else begin
						prev_end_q <= head_end;
						if (last_seg) begin
							pos_q <= POS_END;
							mprev_q <= head_end == addr_ext;
						end
					end
				end
				if (last_seg) begin
					idx_q <= '0;
					full_q <= seg_head.vld;
					if (found_q || uhit) begin
						res_addr_q <= addr_q;
					end else begin
						status_q <= ffha_pkg::ST_NOTFOUND;
						res_size_q <= '0;
					end
				end
			end
			ffha_pkg::S_FREE_UPD: begin
				idx_q <= idx_q + 1'b1;
				if (ins_q) begin
					hold_q <= seg_head;
				end
				if (mprev_q && mnext && idx_q == pos_m1) begin
					del_q <= 1'b1;
				end
				if (!mprev_q && !mnext && !full_q && idx_q == pos_q) begin
					ins_q <= 1'b1;
					hold_q <= seg_head;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

FILE: rtl/first_fit_heap_allocator_top.sv
// channel   signals                        item
// in        in_valid  in_ready  in_data    command, request_size, block_address
// out       out_valid out_ready out_data   status, granted_address, granted_size
// cfg       cfg_valid cfg_ready cfg_data   min_leftover
//
// one item at a time; both tables are rings of cells rotating past the controller
// allocate: a segment pass, then a used pass; no fit ends after the segment pass
// free: two segment passes, the used ring scanned in the first; an unknown address ends after the first
// zero size or full table: no pass, straight to the result
// reset: segment ring holds the whole heap in its first cell, used ring empty
// a result waits in the output register while the next item is taken
module first_fit_heap_allocator_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input ffha_pkg::in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output ffha_pkg::out_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [ffha_pkg::MLW-1:0] cfg_data
);

	ffha_pkg::ent_t seg_q [ffha_pkg::FREE_DEPTH];
	ffha_pkg::ent_t used_q [ffha_pkg::MAX_BLOCKS];
	ffha_pkg::ent_t seg_tail, used_tail;
	ffha_pkg::ring_ctl_t ring_ctl;

	genvar k;
	generate
		for (k = 0; k < ffha_pkg::FREE_DEPTH; k++) begin : g_seg
			ffha_pkg::ent_t init, d;
			if (k == 0) begin : g_first
				assign init = '{vld: 1'b1, start: '0, size: ffha_pkg::SW'(ffha_pkg::HEAP_BYTES)};
			end else begin : g_rest
				assign init = '0;
			end
			if (k == ffha_pkg::FREE_DEPTH - 1) begin : g_tail
				assign d = seg_tail;
			end else begin : g_link
				assign d = seg_q[k+1];
			end
			ffha_cell u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.shift(ring_ctl.seg_shift),
				.init(init),
				.d(d),
				.q(seg_q[k])
			);
		end
		for (k = 0; k < ffha_pkg::MAX_BLOCKS; k++) begin : g_used
			ffha_pkg::ent_t d;
			if (k == ffha_pkg::MAX_BLOCKS - 1) begin : g_tail
				assign d = used_tail;
			end else begin : g_link
				assign d = used_q[k+1];
			end
			ffha_cell u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.shift(ring_ctl.used_shift),
				.init('0),
				.d(d),
				.q(used_q[k])
			);
		end
	endgenerate

	ffha_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.seg_head(seg_q[0]),
		.seg_next(seg_q[1]),
		.seg_tail(seg_tail),
		.used_head(used_q[0]),
		.used_tail(used_tail),
		.ring_ctl(ring_ctl)
	);

endmodule
